// ===== rtl/core/annexb_pkg.sv =====
// Shared types and constants for the Annex B NAL unit splitter.
// Holds the item and record payload structs and the queue push bundle.
// No dependencies.
`default_nettype none

package annexb_pkg;

  // Frame geometry: byte offsets saturate at the last representable position.
  localparam int MAX_FRAME_BYTES = 1048576;
  localparam int POS_W           = 20;
  localparam int SIZE_W          = 21;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);

  // Start code and header constants.
  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [7:0] HDR_TYPE_MASK = 8'h1F;
  localparam logic [2:0] PREFIX_SHORT  = 3'd3;
  localparam logic [2:0] PREFIX_LONG   = 3'd4;
  localparam logic [1:0] ZRUN_MAX      = 2'd3;
  localparam logic [1:0] ZRUN_START    = 2'd2;

  // Configuration register map.
  localparam int          APB_ADDR_W        = 3;
  localparam logic        REG_MAX_UNITS     = 1'b0;
  localparam logic [15:0] MAX_UNITS_DEFAULT = 16'd256;

  // Output queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic {
    REC_UNIT    = 1'b0,
    REC_SUMMARY = 1'b1
  } rec_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic               rec_kind;
    logic [15:0]        unit_index;
    logic [POS_W-1:0]   unit_offset;
    logic [SIZE_W-1:0]  unit_size;
    logic [4:0]         unit_type;
    logic [2:0]         prefix_len;
    logic [15:0]        unit_count;
    logic               overflow;
    logic               last;
  } out_rec_t;

  // One parse step pushes zero, one or two records into the output queue.
  typedef struct packed {
    logic [1:0] num;
    out_rec_t   first;
    out_rec_t   second;
  } rec_push_t;

endpackage : annexb_pkg

`default_nettype wire

// ===== rtl/core/annexb_nal_unit_splitter_top.sv =====
// A byte accepted into the input register is parsed once the result queue can
// take two records; its records then enter the four-entry queue and are offered.
// Throughput: one byte per cycle while the queue has room; the final byte of a
// frame may yield two records, which leave the queue one per cycle unless stalled.
// Input is held off only while that queue cannot take two more records.
// Reset (rst, synchronous) clears all frame state and the queue and sets
// max_units to 256. Top level; instantiates annexb_cfg, annexb_parse, annexb_outq.
`default_nettype none

module annexb_nal_unit_splitter_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire annexb_pkg::in_item_t              item,
  output logic                                   rec_valid,
  input  wire logic                              rec_stall,
  output annexb_pkg::out_rec_t                   rec,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [annexb_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);
  import annexb_pkg::*;

  logic [15:0] max_units;
  logic        queue_room;
  rec_push_t   push;

  // Configuration registers.
  annexb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_units (max_units)
  );

  // Byte parser with its input register.
  annexb_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .max_units  (max_units),
    .queue_room (queue_room),
    .push       (push)
  );

  // Result queue toward the record consumer.
  annexb_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_room (queue_room),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec        (rec)
  );

endmodule : annexb_nal_unit_splitter_top

`default_nettype wire

// ===== rtl/core/annexb_cfg.sv =====
// APB-style configuration register file of the NAL unit splitter.
// Holds max_units; depends on annexb_pkg.
`default_nettype none

module annexb_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [annexb_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output logic      [15:0]                      max_units
);
  import annexb_pkg::*;

  logic wr_en;
  logic reg_sel;

  // The word index is the single address bit above the byte lanes.
  assign reg_sel = paddr[APB_ADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready & (reg_sel == REG_MAX_UNITS);

  // Register write on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= MAX_UNITS_DEFAULT;
    end else if (wr_en) begin
      max_units <= pwdata[15:0];
    end
  end

  // Read data; addresses beyond the map read as zero.
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_MAX_UNITS) begin
      prdata = {16'd0, max_units};
    end
  end

endmodule : annexb_cfg

`default_nettype wire

// ===== rtl/core/annexb_parse.sv =====
// Input register and start code parser of the NAL unit splitter.
// Tracks per-frame state and builds unit and summary records; uses annexb_pkg.
`default_nettype none

module annexb_parse (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire annexb_pkg::in_item_t   item,
  input  wire logic [15:0]            max_units,
  input  wire logic                   queue_room,
  output annexb_pkg::rec_push_t       push
);
  import annexb_pkg::*;

  // Input register.
  logic       hold_valid;
  in_item_t   hold;
  logic       fire;
  logic       load;

  // Frame state.
  logic [POS_W-1:0] byte_pos,    byte_pos_next;
  logic [1:0]       zero_run,    zero_run_next;
  logic             unit_open,   unit_open_next;
  logic             want_header, want_header_next;
  logic [POS_W-1:0] open_offset, open_offset_next;
  logic [4:0]       open_type,   open_type_next;
  logic [2:0]       open_prefix, open_prefix_next;
  logic [15:0]      units_seen,  units_seen_next;
  logic             overflowed,  overflowed_next;

  // Step intermediates.
  logic [7:0]        b;
  logic              fend;
  logic              hdr_take;
  logic              open_mid;
  logic [POS_W-1:0]  offset_mid;
  logic [4:0]        type_mid;
  logic [15:0]       units_mid;
  logic              ovf_mid;
  logic              is_start;
  logic [2:0]        plen;
  logic [POS_W-1:0]  start_pos;
  logic [SIZE_W-1:0] end_pos;
  logic [SIZE_W-1:0] offset_ext;
  logic              emit_unit;
  out_rec_t          unit_rec;
  out_rec_t          sum_rec;

  // The held item is processed once the queue has room for two records.
  assign fire       = hold_valid & queue_room;
  assign load       = ~hold_valid | fire;
  assign item_stall = ~load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_valid) begin
      hold <= item;
    end
  end

  // Header handling, start code detection and record building.
  always_comb begin
    b    = hold.data_byte;
    fend = hold.frame_end;

    hdr_take   = want_header & (units_seen < max_units);
    open_mid   = unit_open | hdr_take;
    offset_mid = hdr_take ? byte_pos : open_offset;
    type_mid   = hdr_take ? 5'(b & HDR_TYPE_MASK) : open_type;
    units_mid  = hdr_take ? units_seen + 16'd1 : units_seen;
    ovf_mid    = overflowed | (want_header & ~hdr_take);

    is_start = (b == START_BYTE) && (zero_run >= ZRUN_START);
    plen     = (zero_run == ZRUN_MAX) ? PREFIX_LONG : PREFIX_SHORT;
    // First byte of the start code, floored at the frame start.
    if (byte_pos >= POS_W'(plen - 3'd1)) begin
      start_pos = byte_pos - POS_W'(plen - 3'd1);
    end else begin
      start_pos = '0;
    end

    // A unit ends at a start code or at the frame end; if both fall on one byte, it ends at the start code.
    emit_unit  = open_mid & (is_start | fend);
    end_pos    = is_start ? {1'b0, start_pos} : ({1'b0, byte_pos} + SIZE_W'(1));
    offset_ext = {1'b0, offset_mid};

    unit_rec             = '0;
    unit_rec.rec_kind    = REC_UNIT;
    unit_rec.unit_index  = units_mid - 16'd1;
    unit_rec.unit_offset = offset_mid;
    unit_rec.unit_size   = (end_pos >= offset_ext) ? end_pos - offset_ext : '0;
    unit_rec.unit_type   = type_mid;
    unit_rec.prefix_len  = open_prefix;

    sum_rec            = '0;
    sum_rec.rec_kind   = REC_SUMMARY;
    sum_rec.unit_count = units_mid;
    sum_rec.overflow   = ovf_mid;
    sum_rec.last       = 1'b1;

    push        = '0;
    push.second = sum_rec;
    if (fire) begin
      push.num   = {1'b0, emit_unit} + {1'b0, fend};
      push.first = emit_unit ? unit_rec : sum_rec;
    end
  end

  // Next frame state.
  always_comb begin
    byte_pos_next    = (byte_pos == POS_LAST) ? byte_pos : byte_pos + POS_W'(1);
    unit_open_next   = open_mid & ~is_start;
    want_header_next = is_start & ~fend;
    open_offset_next = offset_mid;
    open_type_next   = type_mid;
    open_prefix_next = (is_start && !fend) ? plen : open_prefix;
    units_seen_next  = units_mid;
    overflowed_next  = ovf_mid;
    if (is_start) begin
      zero_run_next = '0;
    end else if (b == ZERO_BYTE) begin
      zero_run_next = (zero_run == ZRUN_MAX) ? zero_run : zero_run + 2'd1;
    end else begin
      zero_run_next = '0;
    end

    // The frame end returns all frame state to its reset value.
    if (fend) begin
      byte_pos_next    = '0;
      zero_run_next    = '0;
      unit_open_next   = 1'b0;
      want_header_next = 1'b0;
      open_offset_next = '0;
      open_type_next   = '0;
      open_prefix_next = PREFIX_SHORT;
      units_seen_next  = '0;
      overflowed_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      zero_run    <= '0;
      unit_open   <= 1'b0;
      want_header <= 1'b0;
      open_offset <= '0;
      open_type   <= '0;
      open_prefix <= PREFIX_SHORT;
      units_seen  <= '0;
      overflowed  <= 1'b0;
    end else if (fire) begin
      byte_pos    <= byte_pos_next;
      zero_run    <= zero_run_next;
      unit_open   <= unit_open_next;
      want_header <= want_header_next;
      open_offset <= open_offset_next;
      open_type   <= open_type_next;
      open_prefix <= open_prefix_next;
      units_seen  <= units_seen_next;
      overflowed  <= overflowed_next;
    end
  end

endmodule : annexb_parse

`default_nettype wire

// ===== rtl/core/annexb_outq.sv =====
// Result queue of the NAL unit splitter: takes up to two records per cycle
// and hands out one per transfer. Uses annexb_pkg.
`default_nettype none

module annexb_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire annexb_pkg::rec_push_t push,
  output logic                       queue_room,
  output logic                       rec_valid,
  input  wire logic                  rec_stall,
  output annexb_pkg::out_rec_t       rec
);
  import annexb_pkg::*;

  out_rec_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  // Status and head of the queue.
  assign rec_valid  = (count != '0);
  assign rec        = slots[rd_ptr];
  assign pop        = rec_valid & ~rec_stall;
  assign queue_room = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_next = wr_ptr + QPTR_W'(push.num);
    rd_ptr_next = pop ? rd_ptr + QPTR_W'(1) : rd_ptr;
    count_next  = count + QCNT_W'(push.num) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Record storage; a second record goes into the slot after the first.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      slots[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

endmodule : annexb_outq

`default_nettype wire

// ===== sim/annexb_checker.sv =====
// Predicts and checks the records of the Annex B NAL unit splitter.
// Watches the byte, record and register channels of the block.
// Depends on annexb_pkg for the item and record types and the constants.

module annexb_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  input  wire logic                              item_stall,
  input  wire annexb_pkg::in_item_t              item,
  input  wire logic                              rec_valid,
  input  wire logic                              rec_stall,
  input  wire annexb_pkg::out_rec_t              rec,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [annexb_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  input  wire logic [31:0]                       prdata,
  input  wire logic                              pready,
  output int                                     fail_count,
  output int                                     pending
);
  import annexb_pkg::*;

  // Register copy and per-frame parse state.
  logic [15:0]       capacity;
  logic [POS_W-1:0]  next_pos;
  logic [1:0]        zero_count;
  logic              unit_pending;
  logic              header_next;
  logic [POS_W-1:0]  pend_offset;
  logic [4:0]        pend_type;
  logic [2:0]        pend_prefix;
  logic [15:0]       units_found;
  logic              dropped;

  out_rec_t expected_recs[$];
  int       recs_seen;

  initial begin
    fail_count = 0;
    recs_seen  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_frame();
    next_pos     = '0;
    zero_count   = '0;
    unit_pending = 1'b0;
    header_next  = 1'b0;
    pend_offset  = '0;
    pend_type    = '0;
    pend_prefix  = PREFIX_SHORT;
    units_found  = '0;
    dropped      = 1'b0;
  endfunction

  // Closes the pending unit; its size runs from the header to end_pos.
  function automatic void close_unit(input logic [SIZE_W-1:0] end_pos);
    out_rec_t r;
    r = '0;
    r.rec_kind    = REC_UNIT;
    r.unit_index  = units_found - 16'd1;
    r.unit_offset = pend_offset;
    r.unit_size   = (end_pos >= {1'b0, pend_offset}) ? end_pos - {1'b0, pend_offset} : '0;
    r.unit_type   = pend_type;
    r.prefix_len  = pend_prefix;
    expected_recs.push_back(r);
    unit_pending = 1'b0;
  endfunction

  // One byte of the frame: header capture, start code search, frame end.
  function automatic void parse_byte(input logic [7:0] b, input logic fend);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] back;
    logic [2:0]       plen;
    out_rec_t         summary;
    p = next_pos;
    if (header_next) begin
      header_next = 1'b0;
      if (units_found < capacity) begin
        units_found++;
        unit_pending = 1'b1;
        pend_offset  = p;
        pend_type    = b[4:0];
      end else begin
        dropped = 1'b1;
      end
    end
    if (b == START_BYTE && zero_count >= ZRUN_START) begin
      plen = (zero_count == ZRUN_MAX) ? PREFIX_LONG : PREFIX_SHORT;
      back = POS_W'(plen - 3'd1);
      if (unit_pending)
        close_unit((p >= back) ? {1'b0, p - back} : '0);
      zero_count = '0;
      if (!fend) begin
        header_next = 1'b1;
        pend_prefix = plen;
      end
    end else if (b == ZERO_BYTE) begin
      if (zero_count != ZRUN_MAX)
        zero_count++;
    end else begin
      zero_count = '0;
    end
    // Offsets stop at the last position of a maximal frame.
    next_pos = (p < POS_LAST) ? p + POS_W'(1) : p;
    if (fend) begin
      if (unit_pending)
        close_unit({1'b0, p} + SIZE_W'(1));
      summary = '0;
      summary.rec_kind   = REC_SUMMARY;
      summary.unit_count = units_found;
      summary.overflow   = dropped;
      summary.last       = 1'b1;
      expected_recs.push_back(summary);
      clear_frame();
    end
  endfunction

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s: got %0d, expected %0d",
                                recs_seen, field, got, want));
  endtask

  // Register transfers, byte transfers and record transfers at each edge.
  always @(posedge clk) begin
    if (rst) begin
      capacity = MAX_UNITS_DEFAULT;
      clear_frame();
      expected_recs.delete();
    end else begin
      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_MAX_UNITS) begin
        if (pwrite)
          capacity = pwdata[15:0];
        else if (prdata[15:0] !== capacity)
          report_mismatch($sformatf("max_units read %0h, expected %0h",
                                    prdata[15:0], capacity));
      end
      if (item_valid && !item_stall)
        parse_byte(item.data_byte, item.frame_end);
      if (rec_valid && !rec_stall) begin
        if (expected_recs.size() == 0) begin
          report_mismatch($sformatf("record %0d arrived with none expected", recs_seen));
        end else begin
          out_rec_t want;
          want = expected_recs.pop_front();
          compare_field("rec_kind", rec.rec_kind, want.rec_kind);
          compare_field("unit_index", rec.unit_index, want.unit_index);
          compare_field("unit_offset", rec.unit_offset, want.unit_offset);
          compare_field("unit_size", rec.unit_size, want.unit_size);
          compare_field("unit_type", rec.unit_type, want.unit_type);
          compare_field("prefix_len", rec.prefix_len, want.prefix_len);
          compare_field("unit_count", rec.unit_count, want.unit_count);
          compare_field("overflow", rec.overflow, want.overflow);
          compare_field("last", rec.last, want.last);
        end
        recs_seen++;
      end
    end
    pending <= expected_recs.size();
  end

endmodule

// ===== sim/annexb_nal_unit_splitter_top_tb.sv =====
// Stimulus and verdict for the Annex B NAL unit splitter top level.
// Drives byte frames and max_units writes; annexb_checker predicts and compares.
// Depends on annexb_pkg, annexb_checker and annexb_nal_unit_splitter_top.

module annexb_nal_unit_splitter_top_tb;
  import annexb_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int IDLE_PCT       = 36;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int NUM_PHASES     = 6;
  localparam int SQUEEZE_CYCLES = 120;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SPARE_REG      = 1;

  localparam logic [APB_ADDR_W-1:0] MAX_UNITS_ADDR = APB_ADDR_W'(REG_MAX_UNITS) << 2;
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR     = APB_ADDR_W'(SPARE_REG) << 2;
  localparam logic                  APB_WRITE      = 1'b1;
  localparam logic                  APB_READ       = 1'b0;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  in_item_t              item       = '0;
  logic                  rec_valid;
  logic                  rec_stall  = 1'b0;
  out_rec_t              rec;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_ADDR_W-1:0] paddr      = '0;
  logic [31:0]           pwdata     = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic       idling      = 1'b0;
  logic       squeeze_req = 1'b0;
  int         bytes_sent  = 0;
  int         fail_count;
  int         pending;
  logic [7:0] frame_q[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  annexb_nal_unit_splitter_top dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .rec_valid(rec_valid), .rec_stall(rec_stall), .rec(rec),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  annexb_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .rec_valid(rec_valid), .rec_stall(rec_stall), .rec(rec),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // Byte mix that favors zeros and ones so start codes appear by chance.
  function automatic logic [7:0] biased_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20)
      return ZERO_BYTE;
    if (r < 30)
      return START_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // Offers one byte and returns at the edge of its transfer.
  task automatic send_byte(input logic [7:0] b, input logic fend);
    while (idling && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: b, frame_end: fend};
    do @(posedge clk); while (item_stall);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i])
      send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Waits until every expected record has arrived and the pipeline is empty.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic [APB_ADDR_W-1:0] addr, input logic wr,
                            input logic [31:0] data);
    psel   <= 1'b1;
    pwrite <= wr;
    paddr  <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long counted hold when requested.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        rec_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES - 1) @(posedge clk);
        squeeze_req = 1'b0;
      end else begin
        rec_stall <= idling && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int          random_base;
    int          shape;
    int          n_units;
    int          zeros;
    logic [15:0] cap;

    repeat (2) @(posedge clk);
    rst    <= 1'b0;
    idling = 1'b1;

    // Leading junk, short and long start codes, zero header, start code at frame end.
    frame_q = '{8'hFF, ZERO_BYTE, ZERO_BYTE, START_BYTE, 8'hE5,
                ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, START_BYTE,
                ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, START_BYTE, 8'h7F,
                ZERO_BYTE, ZERO_BYTE, START_BYTE};
    send_frame();
    // Header as the final byte of the frame.
    frame_q = '{ZERO_BYTE, ZERO_BYTE, START_BYTE, 8'h1F};
    send_frame();
    drain();

    // Capacity of one, then of zero: later units are dropped and flagged.
    frame_q = '{ZERO_BYTE, ZERO_BYTE, START_BYTE, 8'h41,
                ZERO_BYTE, ZERO_BYTE, START_BYTE, 8'h42, 8'hAB};
    apb_access(MAX_UNITS_ADDR, APB_WRITE, 32'd1);
    apb_access(MAX_UNITS_ADDR, APB_READ, '0);
    send_frame();
    drain();
    apb_access(MAX_UNITS_ADDR, APB_WRITE, 32'd0);
    apb_access(MAX_UNITS_ADDR, APB_READ, '0);
    send_frame();
    drain();

    // A write past the register list must leave max_units alone.
    apb_access(SPARE_ADDR, APB_WRITE, 32'hFFFF_FFFF);
    apb_access(MAX_UNITS_ADDR, APB_READ, '0);

    // Random frames, mostly well formed, in phases with different capacities.
    random_base = bytes_sent;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       cap = 16'd3;
        1:       cap = 16'd1;
        2:       cap = 16'hFFFF;
        3:       cap = 16'd2;
        4:       cap = 16'($urandom_range(8, 1));
        default: cap = MAX_UNITS_DEFAULT;
      endcase
      apb_access(MAX_UNITS_ADDR, APB_WRITE, {16'd0, cap});
      apb_access(MAX_UNITS_ADDR, APB_READ, '0);
      idling = (phase != 2);
      if (phase == 3)
        squeeze_req = 1'b1;
      while (bytes_sent - random_base < (phase + 1) * RANDOM_ITEMS / NUM_PHASES) begin
        frame_q.delete();
        shape = $urandom_range(99);
        if (shape < 10) begin
          // Noise frame with no particular structure.
          repeat ($urandom_range(24, 1)) frame_q.push_back(biased_byte());
        end else begin
          repeat ($urandom_range(3, 0)) frame_q.push_back(8'($urandom_range(255)));
          n_units = $urandom_range(8, 1);
          for (int u = 0; u < n_units; u++) begin
            shape = (u == 0) ? shape : shape;
            zeros = $urandom_range(99);
            zeros = (zeros < 70) ? 2 : (zeros < 90) ? 3 : $urandom_range(6, 4);
            repeat (zeros) frame_q.push_back(ZERO_BYTE);
            // Now and then the start code is left incomplete.
            if ($urandom_range(99) >= 5)
              frame_q.push_back(START_BYTE);
            frame_q.push_back(($urandom_range(99) < 10) ? ZERO_BYTE
                                                        : 8'($urandom_range(255)));
            if (u < n_units - 1 || shape >= 30)
              repeat ($urandom_range(12, 0)) frame_q.push_back(biased_byte());
          end
          if (shape < 20) begin
            frame_q.push_back(ZERO_BYTE);
            frame_q.push_back(ZERO_BYTE);
            frame_q.push_back(START_BYTE);
          end
        end
        send_frame();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("annexb_nal_unit_splitter_top test passed");
    else
      $display("annexb_nal_unit_splitter_top test failed");
    $finish;
  end

  // Hard limit on the run.
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("annexb_nal_unit_splitter_top test failed");
    $finish;
  end

endmodule
